// File: rtl/core/ntr_pkg.sv
package ntr_pkg;

  // Field widths on the streams and the configuration port
  localparam int OP_W        = 2;
  localparam int SEQ_W       = 16;
  localparam int TIME_W      = 32;
  localparam int STATUS_W    = 3;
  localparam int RETRY_OUT_W = 4;
  localparam int CFG_RETRY_W = 4;
  localparam int CFG_IVL_W   = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 24;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TRACK   = 2'd0;
  localparam logic [OP_W-1:0] OP_NACK    = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEANUP = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_TRACKED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SKIPPED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SWEPT     = 3'd5;

  // Configuration register indexes
  localparam logic CFG_MAX_RETRIES    = 1'b0;
  localparam logic CFG_SWEEP_INTERVAL = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;     // clearing pass: zero entry at counter, advance
    logic capture;    // input beat taken: latch fields, read its entry
    logic finish;     // resolve item: update entry, load result
    logic stamp;      // record sweep time
    logic sweep_rd;   // sweep: read entry at counter, advance
    logic load_swept; // load sweep-done result
  } ntr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_last;    // counter at last table entry
    logic out_busy;    // result register full and not drained this cycle
    logic sweep_start; // cleanup item and interval elapsed
  } ntr_stat_t;

endpackage

// File: rtl/core/nack_retransmit_tracker_top.sv
// Retry table for NACK-driven retransmission, indexed by the low SEQ_BITS of the
// sequence number. Each item gives exactly one result beat. Track, NACK, unknown
// operations and cleanups that find the interval not yet elapsed are accepted and
// then resolved by one read-modify-write of the table RAM (one write port, one
// registered read port), so one item is in the block at a time. A cleanup that
// sweeps walks the whole table one entry per cycle through the same RAM ports
// before its result.
// After reset a clearing pass zeroes the whole table, during which no item is
// accepted; configuration writes are always taken, but should be made only while
// the block is idle. A finished result waits in an output register, and the next
// item is accepted meanwhile.
module nack_retransmit_tracker_top import ntr_pkg::*; #(
  parameter int SEQ_BITS   = 16,
  parameter int RETRY_BITS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [1:0] operation, [17:2] seq_number, [49:18] now_time, [55:50] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [2:0] status, [18:3] resend_seq, [22:19] retry_number, [23] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ntr_cmd_t  cmd;
  ntr_stat_t stat;

  assign cfg_ready = 1'b1;

  ntr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ntr_dp #(
    .SEQ_BITS   (SEQ_BITS),
    .RETRY_BITS (RETRY_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_data    (s_tdata),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata)
  );

endmodule

// File: rtl/core/ntr_ram.sv
module ntr_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/ntr_ctrl.sv
module ntr_ctrl import ntr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ntr_stat_t stat,
  output ntr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RESOLVE,
    S_SWEEP,
    S_SWEEP_TAIL,
    S_SWEEP_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // Command decode and next state
  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.cnt_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (stat.sweep_start) begin
          cmd.stamp  = 1'b1;
          state_next = S_SWEEP;
        end else if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd.sweep_rd = 1'b1;
        if (stat.cnt_last) begin
          state_next = S_SWEEP_TAIL;
        end
      end
      // last write-back of the sweep lands here
      S_SWEEP_TAIL: begin
        state_next = S_SWEEP_DONE;
      end
      S_SWEEP_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_swept = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/core/ntr_dp.sv
module ntr_dp import ntr_pkg::*; #(
  parameter int SEQ_BITS   = 16,
  parameter int RETRY_BITS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ntr_cmd_t              cmd,
  output ntr_stat_t             stat,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic                  cfg_wr,
  input  logic                  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int DEPTH   = 1 << SEQ_BITS;
  localparam int ENTRY_W = RETRY_BITS + 1;
  localparam int CMP_W   = (RETRY_BITS > CFG_RETRY_W) ? RETRY_BITS : CFG_RETRY_W;

  logic [CFG_RETRY_W-1:0] max_retries;
  logic [CFG_IVL_W-1:0]   sweep_interval;
  logic [TIME_W-1:0]      last_sweep;
  logic [OP_W-1:0]        op_q;
  logic [SEQ_BITS-1:0]    idx_q;
  logic [TIME_W-1:0]      now_q;
  logic [SEQ_BITS-1:0]    cnt;
  logic                   pend;
  logic [SEQ_BITS-1:0]    pend_addr;

  logic                   wr_en;
  logic [SEQ_BITS-1:0]    wr_addr;
  logic [ENTRY_W-1:0]     wr_data;
  logic [SEQ_BITS-1:0]    rd_addr;
  logic [ENTRY_W-1:0]     rd_data;

  logic                   rd_valid;
  logic [RETRY_BITS-1:0]  rd_retry;
  logic [RETRY_BITS-1:0]  retry_inc;
  logic [CMP_W-1:0]       retry_ext;
  logic                   exhausted;
  logic                   due;

  logic                   res_wr;
  logic [ENTRY_W-1:0]     res_entry;
  logic [STATUS_W-1:0]    res_status;
  logic [SEQ_W-1:0]       res_seq;
  logic [RETRY_OUT_W-1:0] res_retry;

  logic [STATUS_W-1:0]    out_status;
  logic [SEQ_W-1:0]       out_seq;
  logic [RETRY_OUT_W-1:0] out_retry;

  // Table: valid bit above the retry count
  ntr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_valid  = rd_data[RETRY_BITS];
  assign rd_retry  = rd_data[RETRY_BITS-1:0];
  assign exhausted = CMP_W'(rd_retry) >= CMP_W'(max_retries);
  assign retry_inc = (&rd_retry) ? rd_retry : rd_retry + RETRY_BITS'(1);
  assign retry_ext = CMP_W'(retry_inc);

  // Elapsed time modulo 2^32 against the interval
  assign due = (now_q - last_sweep) >= TIME_W'(sweep_interval);

  // Read address: new item, sweep walk, or held item
  always_comb begin
    if (cmd.capture) begin
      rd_addr = in_data[OP_W +: SEQ_BITS];
    end else if (cmd.sweep_rd) begin
      rd_addr = cnt;
    end else begin
      rd_addr = idx_q;
    end
  end

  // Per-item resolution
  always_comb begin
    res_wr     = 1'b0;
    res_entry  = '0;
    res_status = ST_NOT_FOUND;
    res_seq    = '0;
    res_retry  = '0;
    case (op_q)
      OP_TRACK: begin
        res_wr     = 1'b1;
        res_entry  = {1'b1, {RETRY_BITS{1'b0}}};
        res_status = ST_TRACKED;
      end
      OP_NACK: begin
        if (rd_valid && exhausted) begin
          res_wr     = 1'b1;
          res_entry  = {1'b0, rd_retry};
          res_status = ST_EXHAUSTED;
        end else if (rd_valid) begin
          res_wr     = 1'b1;
          res_entry  = {1'b1, retry_inc};
          res_status = ST_GRANTED;
          res_seq    = SEQ_W'(idx_q);
          res_retry  = retry_ext[RETRY_OUT_W-1:0];
        end
      end
      OP_CLEANUP: begin
        res_status = ST_SKIPPED;
      end
      default: begin
        res_status = ST_NOT_FOUND;
      end
    endcase
  end

  // Write port arbitration; at most one source per cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = res_entry;
    if (cmd.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = cnt;
      wr_data = '0;
    end else if (pend) begin
      wr_en   = rd_valid && exhausted;
      wr_addr = pend_addr;
      wr_data = {1'b0, rd_retry};
    end else if (cmd.finish) begin
      wr_en = res_wr;
    end
  end

  assign stat.cnt_last    = &cnt;
  assign stat.out_busy    = out_valid && !out_ready;
  assign stat.sweep_start = (op_q == OP_CLEANUP) && due;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_retries    <= CFG_RETRY_W'(3);
      sweep_interval <= CFG_IVL_W'(1000);
      last_sweep     <= '0;
      cnt            <= '0;
      pend           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          CFG_MAX_RETRIES:    max_retries    <= cfg_data[CFG_RETRY_W-1:0];
          CFG_SWEEP_INTERVAL: sweep_interval <= cfg_data[CFG_IVL_W-1:0];
          default: ;
        endcase
      end
      if (cmd.stamp) begin
        last_sweep <= now_q;
      end
      if (cmd.clr_wr || cmd.sweep_rd) begin
        cnt <= cnt + SEQ_BITS'(1);
      end
      pend <= cmd.sweep_rd;
      if (cmd.finish || cmd.load_swept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_addr <= cnt;
    if (cmd.capture) begin
      op_q  <= in_data[OP_W-1:0];
      idx_q <= in_data[OP_W +: SEQ_BITS];
      now_q <= in_data[OP_W+SEQ_W +: TIME_W];
    end
    if (cmd.finish) begin
      out_status <= res_status;
      out_seq    <= res_seq;
      out_retry  <= res_retry;
    end else if (cmd.load_swept) begin
      out_status <= ST_SWEPT;
      out_seq    <= '0;
      out_retry  <= '0;
    end
  end

  assign out_data = {1'b0, out_retry, out_seq, out_status};

endmodule

// File: rtl/core/ntr_checker.sv
module ntr_checker import ntr_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  logic       in_beat;
  logic       out_beat;
  logic [1:0] pending;

  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;

  // Items accepted whose result beat has not gone yet
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_beat) - 2'(out_beat);
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // One item at a time: no input taken in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !s_tready)
    else $error("input accepted on consecutive cycles");

  // Every result belongs to an accepted item
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_beat |-> pending != 2'd0)
    else $error("result beat without an accepted item");

  // Status codes stay within the defined set, upper pad bit zero
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] != 3'd6) && (m_tdata[2:0] != 3'd7) && !m_tdata[23])
    else $error("undefined status code");

  // A grant never carries a zero retry number
  a_grant: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == ST_GRANTED) |-> m_tdata[22:19] != 4'd0)
    else $error("grant with zero retry number");

endmodule

bind nack_retransmit_tracker_top ntr_checker u_ntr_checker (.*);

// File: bench/nack_retransmit_tracker_top_tb.sv
`timescale 1ns / 1ps

module nack_retransmit_tracker_top_tb;
  import ntr_pkg::*;

  localparam int    HALF_PERIOD = 5;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam int    POOL_SIZE   = 8;
  localparam int    TABLE_SIZE  = 65536;
  // operation code the block does not implement
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  // one input beat, last field in the lowest bits
  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [SEQ_W-1:0]  seq;
    logic [OP_W-1:0]   op;
  } request_t;

  // one result beat, last field in the lowest bits
  typedef struct packed {
    logic [RETRY_OUT_W-1:0] retries;
    logic [SEQ_W-1:0]       seq;
    logic [STATUS_W-1:0]    status;
  } answer_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = CFG_MAX_RETRIES;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  nack_retransmit_tracker_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // pending requests and the answers they must produce, in order
  request_t request_q[$];
  answer_t  answer_q[$];

  // shadow of the retry table and its registers
  bit                     seq_live [TABLE_SIZE];
  logic [RETRY_OUT_W-1:0] seq_tries [TABLE_SIZE];
  logic [TIME_W-1:0]      mdl_last_sweep = '0;
  logic [CFG_RETRY_W-1:0] mdl_max_retries = 4'd3;
  logic [CFG_IVL_W-1:0]   mdl_interval = 16'd1000;

  logic [SEQ_W-1:0] seq_pool [POOL_SIZE];

  int     err_cnt = 0;
  int     n_items = 0;
  int     n_beats = 0;
  int     n_sweeps = 0;
  int     n_writes = 0;
  int     sent_cnt = 0;
  int     burst_left = 0;
  int     gap_left = 0;
  int     hold_cnt = 0;
  bit     hold_done = 1'b0;
  bit     rdy_pick;
  bit     s_took = 1'b0;
  logic [9:0] rdy_ctr = '0;
  longint cyc = 0;
  answer_t got_a;
  answer_t want_a;

  // Resolve one request against the shadow table
  function automatic answer_t retry_table_step(request_t rq);
    answer_t            a;
    logic [RETRY_OUT_W-1:0] n;
    logic [TIME_W-1:0]  gap;
    a = '0;
    a.status = ST_NOT_FOUND;
    case (rq.op)
      OP_TRACK: begin
        seq_live[rq.seq] = 1'b1;
        seq_tries[rq.seq] = '0;
        a.status = ST_TRACKED;
      end
      OP_NACK: begin
        if (seq_live[rq.seq]) begin
          n = seq_tries[rq.seq];
          if (n >= mdl_max_retries) begin
            seq_live[rq.seq] = 1'b0;
            a.status = ST_EXHAUSTED;
          end else begin
            // saturate at the widest count
            if (n != {RETRY_OUT_W{1'b1}}) n = n + 1'b1;
            seq_tries[rq.seq] = n;
            a.status = ST_GRANTED;
            a.seq = rq.seq;
            a.retries = n;
          end
        end
      end
      OP_CLEANUP: begin
        gap = rq.stamp - mdl_last_sweep;
        if (gap < TIME_W'(mdl_interval)) begin
          a.status = ST_SKIPPED;
        end else begin
          mdl_last_sweep = rq.stamp;
          for (int k = 0; k < TABLE_SIZE; k++) begin
            if (seq_live[k] && seq_tries[k] >= mdl_max_retries) seq_live[k] = 1'b0;
          end
          a.status = ST_SWEPT;
          n_sweeps++;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic push_request(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq,
                              input logic [TIME_W-1:0] stamp);
    request_t rq;
    rq.op = op;
    rq.seq = seq;
    rq.stamp = stamp;
    request_q = {request_q, rq};
    answer_q = {answer_q, retry_table_step(rq)};
    n_items++;
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_MAX_RETRIES) mdl_max_retries = val[CFG_RETRY_W-1:0];
    else mdl_interval = val[CFG_IVL_W-1:0];
    n_writes++;
  endtask

  // block is idle once every request is taken and every answer has come
  task automatic wait_idle();
    while (request_q.size() != 0 || answer_q.size() != 0 || s_tvalid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH beat %0d %s: got 0x%0h, expected 0x%0h", n_beats, what, got, want);
    err_cnt++;
  endtask

  // Random traffic, mostly on a small pool of live sequences
  task automatic run_random(input int count, input int track_pct, input int sweeps);
    logic [OP_W-1:0]   op;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] stamp;
    int                roll;
    int                j;
    repeat (count) begin
      stamp = $urandom();
      seq   = SEQ_W'($urandom_range(0, 65535));
      roll  = $urandom_range(0, 99);
      j     = $urandom_range(0, POOL_SIZE - 1);
      if (roll < track_pct) begin
        op = OP_TRACK;
        if ($urandom_range(0, 1) != 0) seq_pool[j] = seq;
        else seq = seq_pool[j];
      end else if (roll < 90) begin
        op = OP_NACK;
        if ($urandom_range(0, 6) != 0) seq = seq_pool[j];
      end else if (roll < 97) begin
        op = OP_CLEANUP;
        if (sweeps > 0 && $urandom_range(0, 15) == 0) begin
          // interval elapsed: on or just past the boundary, or well past it
          sweeps--;
          stamp = mdl_last_sweep + TIME_W'(mdl_interval) +
                  (($urandom_range(0, 1) != 0) ? TIME_W'($urandom_range(0, 3))
                                                : ($urandom() >> 1));
        end else if (mdl_interval != 0) begin
          stamp = mdl_last_sweep +
                  (($urandom_range(0, 1) != 0) ? TIME_W'(mdl_interval) - 1'b1
                                                : TIME_W'($urandom_range(0, mdl_interval - 1)));
        end else begin
          // a zero interval would sweep every time: send a nack instead
          op  = OP_NACK;
          seq = seq_pool[j];
        end
      end else begin
        op = OP_UNKNOWN;
      end
      push_request(op, seq, stamp);
    end
  endtask

  // Sender: bursts of random length with random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_took) begin
        void'(request_q.pop_front());
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_tvalid || s_took) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (request_q.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {{(IN_DATA_W - $bits(request_t)){1'b0}}, request_q[0]};
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern steps through four modes on a free-running counter, plus one long hold-off
  always @(negedge clk) begin
    rdy_ctr <= rdy_ctr + 1'b1;
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && sent_cnt >= 300) begin
      hold_cnt  <= 400;
      hold_done <= 1'b1;
    end
    case (rdy_ctr[8:7])
      2'd0:    rdy_pick = 1'b1;
      2'd1:    rdy_pick = ($urandom_range(0, 1) != 0);
      2'd2:    rdy_pick = (rdy_ctr[1:0] != 2'd0);
      default: rdy_pick = ($urandom_range(0, 3) == 0);
    endcase
    m_tready <= !rst && hold_cnt == 0 && rdy_pick;
  end

  // Monitor: note input beats taken, check each result beat
  always @(posedge clk) begin
    s_took <= !rst && s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      n_beats++;
      got_a = m_tdata[$bits(answer_t)-1:0];
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected beat", int'(m_tdata), 0);
      end else begin
        want_a = answer_q.pop_front();
        if (got_a.status != want_a.status)
          report_mismatch("status", int'(got_a.status), int'(want_a.status));
        if (got_a.seq != want_a.seq)
          report_mismatch("resend_seq", int'(got_a.seq), int'(want_a.seq));
        if (got_a.retries != want_a.retries)
          report_mismatch("retry_number", int'(got_a.retries), int'(want_a.retries));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d answers outstanding", cyc, answer_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    for (int j = 0; j < POOL_SIZE; j++) seq_pool[j] = SEQ_W'($urandom_range(0, 65535));
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // limit of two retries, table ends, exhaustion and both sweep outcomes
    write_reg(CFG_MAX_RETRIES, 16'd2);
    write_reg(CFG_SWEEP_INTERVAL, 16'd1000);
    push_request(OP_TRACK, 16'h0000, 32'h0);
    push_request(OP_TRACK, 16'hFFFF, 32'h0);
    push_request(OP_NACK, 16'h0000, 32'h0);
    push_request(OP_NACK, 16'h0000, 32'h0);
    push_request(OP_NACK, 16'h0000, 32'h0);            // retries used up: dropped
    push_request(OP_NACK, 16'h0000, 32'h0);            // gone now
    push_request(OP_NACK, 16'hFFFF, 32'h0);
    push_request(OP_UNKNOWN, 16'hFFFF, 32'hFFFF_FFFF);
    push_request(OP_CLEANUP, 16'h0, 32'd999);          // one short of the interval
    push_request(OP_CLEANUP, 16'h0, 32'd1000);         // exactly on it
    push_request(OP_NACK, 16'hFFFF, 32'h0);
    push_request(OP_CLEANUP, 16'h0, 32'd1999);
    push_request(OP_CLEANUP, 16'h0, 32'd2000);         // sweep drops the spent entry
    push_request(OP_NACK, 16'hFFFF, 32'h0);
    push_request(OP_TRACK, 16'h1234, 32'hFFFF_FFFF);
    wait_idle();

    // zero retry limit and zero interval; cleanup time wraps below the last sweep
    write_reg(CFG_MAX_RETRIES, 16'd0);
    write_reg(CFG_SWEEP_INTERVAL, 16'd0);
    push_request(OP_TRACK, 16'd5, 32'h0);
    push_request(OP_NACK, 16'd5, 32'h0);
    push_request(OP_TRACK, 16'd6, 32'h0);
    push_request(OP_CLEANUP, 16'h0, 32'h0);
    push_request(OP_NACK, 16'd6, 32'h0);
    push_request(OP_NACK, 16'h1234, 32'h0);
    wait_idle();

    // random phases over several register settings
    write_reg(CFG_MAX_RETRIES, 16'd15);
    write_reg(CFG_SWEEP_INTERVAL, 16'hFFFF);
    run_random(410, 4, 2);
    wait_idle();

    write_reg(CFG_MAX_RETRIES, 16'd0);
    write_reg(CFG_SWEEP_INTERVAL, 16'd0);
    run_random(410, 30, 2);
    wait_idle();

    write_reg(CFG_MAX_RETRIES, CFG_DATA_W'($urandom_range(1, 14)));
    write_reg(CFG_SWEEP_INTERVAL, CFG_DATA_W'($urandom_range(1, 65534)));
    run_random(410, 15, 2);
    wait_idle();

    write_reg(CFG_MAX_RETRIES, 16'd3);
    write_reg(CFG_SWEEP_INTERVAL, 16'd1000);
    run_random(410, 15, 2);
    wait_idle();
    repeat (8) @(posedge clk);

    $display("Covered %0d requests, %0d result beats, %0d full table sweeps, %0d reg writes",
             n_items, n_beats, n_sweeps, n_writes);
    $display("Retry limits 0, 2, 3, 15 and one random; intervals 0, 1000, 65535 and one random");
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
